[hdl/strs_pkg.sv]
// Shared types and codes for the segment tree range sum block.
// Used by strs_cell and segment_tree_range_sum; depends on nothing.
package strs_pkg;

    localparam int DATA_W   = 64;
    localparam int DELTA_W  = 32;
    localparam int FIELD_W  = 10;
    localparam int S_DATA_W = 64;

    typedef enum logic {
        REQ_ADD   = 1'b0,
        REQ_QUERY = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic valid;
        logic query;
        logic skip;
    } strs_tok_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_A0,
        CS_A1,
        CS_Q0,
        CS_Q1,
        CS_Q2
    } cell_state_t;

    typedef enum logic [1:0] {
        TS_CLEAR,
        TS_IDLE,
        TS_BUSY
    } top_state_t;

endpackage

[hdl/strs_ram.sv]
// Generic single write port RAM with one registered read port.
// No dependencies.
module strs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

[hdl/strs_cell.sv]
// One tree level: holds that level's node sums in a RAM, zeroes them when clr_en is set, and updates or
// reads them for a request, then hands the request to the next level.
// Depends on strs_pkg and strs_ram.
module strs_cell import strs_pkg::*; #(
    parameter int DEPTH = 2,
    parameter int IW    = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            clr_en,
    input  logic [IW-1:0]   clr_addr,
    input  strs_tok_t       in_tok,
    input  logic [IW-1:0]   in_l,
    input  logic [IW-1:0]   in_r,
    input  logic [IW-1:0]   in_idx,
    input  logic [DATA_W-1:0] in_delta,
    input  logic [DATA_W-1:0] in_acc,
    output strs_tok_t       out_tok,
    output logic [IW-1:0]   out_l,
    output logic [IW-1:0]   out_r,
    output logic [IW-1:0]   out_idx,
    output logic [DATA_W-1:0] out_delta,
    output logic [DATA_W-1:0] out_acc
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cell_state_t state_reg, state_next;
    logic query_reg, skip_reg;
    logic [IW-1:0] l_reg, r_reg, idx_reg;
    logic [DATA_W-1:0] delta_reg, acc_reg;
    logic out_valid_reg, out_query_reg, out_skip_reg;
    logic [IW-1:0] out_l_reg, out_r_reg, out_idx_reg;
    logic [DATA_W-1:0] out_delta_reg, out_acc_reg;

    logic [AW-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic lt, l_step, r_step;
    logic [IW-1:0] r_dec;

    assign lt     = l_reg < r_reg;
    assign l_step = lt & l_reg[0];
    assign r_step = lt & r_reg[0];
    assign r_dec  = r_reg - IW'(1);

    strs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (in_tok.valid) begin
                    state_next = in_tok.query ? CS_Q0 : CS_A0;
                end
            end
            CS_A0:   state_next = CS_A1;
            CS_A1:   state_next = CS_IDLE;
            CS_Q0:   state_next = CS_Q1;
            CS_Q1:   state_next = CS_Q2;
            CS_Q2:   state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb begin
        rd_addr = l_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = clr_addr[AW-1:0];
        wr_data = '0;
        if (clr_en) begin
            wr_en = (32'(clr_addr) < DEPTH);
        end
        unique case (state_reg)
            CS_A0:   rd_addr = idx_reg[AW-1:0];
            CS_A1: begin
                rd_addr = idx_reg[AW-1:0];
                if (!skip_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg[AW-1:0];
                    wr_data = rd_data + delta_reg;
                end
            end
            CS_Q1:   rd_addr = r_dec[AW-1:0];
            default: rd_addr = l_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= (state_reg == CS_A1) || (state_reg == CS_Q2);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            CS_IDLE: begin
                query_reg <= in_tok.query;
                skip_reg  <= in_tok.skip;
                l_reg     <= in_l;
                r_reg     <= in_r;
                idx_reg   <= in_idx;
                delta_reg <= in_delta;
                acc_reg   <= in_acc;
            end
            CS_Q1: begin
                if (l_step) begin
                    acc_reg <= acc_reg + rd_data;
                end
            end
            default: ;
        endcase
        out_query_reg <= query_reg;
        out_skip_reg  <= skip_reg;
        out_idx_reg   <= idx_reg >> 1;
        out_delta_reg <= delta_reg;
        out_l_reg     <= (l_reg + IW'(l_step)) >> 1;
        out_r_reg     <= r_reg >> 1;
        out_acc_reg   <= r_step ? acc_reg + rd_data : acc_reg;
    end

    assign out_tok   = '{valid: out_valid_reg, query: out_query_reg, skip: out_skip_reg};
    assign out_l     = out_l_reg;
    assign out_r     = out_r_reg;
    assign out_idx   = out_idx_reg;
    assign out_delta = out_delta_reg;
    assign out_acc   = out_acc_reg;
endmodule

[hdl/segment_tree_range_sum.sv]
// Top level of the segment tree range sum block: input decode, chain of
// level cells, result register. Depends on strs_pkg and strs_cell.
//
// Usage: requests arrive on the s_ stream channel. s_tuser carries the
// request kind (0 adds delta to one leaf, 1 asks for a range sum);
// s_tdata carries leaf_index, delta, range_first and range_last.
// Each query yields one 64-bit wrapped sum on the m_ channel; an add
// yields nothing. A request passes through one cell per tree level,
// log2(PADDED)+1 cells, from the leaves to the root. A cell steps
// through states A0 and A1 on an add and Q0, Q1 and Q2 on a query,
// as its RAM read is registered. A query result appears on m_tvalid
// in the same cycle as s_tready rises again. One request is in flight
// at a time; the next is accepted once an add has left the chain, or
// once a query's result has moved into the output register, even
// while that result still waits there to be taken.
// After reset the node RAMs are zeroed by a clearing pass that steps
// clr_cnt_reg through every address up to PADDED-1, during which
// s_tready is low. When the receiver stalls, the result is held in the
// output register and a second finished result is held back until the
// first has been taken.
module segment_tree_range_sum import strs_pkg::*; #(
    parameter int LEAVES = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // leaf_index[9:0], delta[41:10], range_first[51:42], range_last[61:52]
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // range_total[63:0]
    output logic [DATA_W-1:0]   m_tdata
);
    localparam int LW     = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int PADDED = 1 << LW;
    localparam int IW     = LW + 1;
    localparam int NLEV   = LW + 1;

    top_state_t state_reg, state_next;
    logic [IW-1:0] clr_cnt_reg;
    logic clr_done;

    strs_tok_t           tok    [NLEV+1];
    logic [IW-1:0]       lv_l   [NLEV+1];
    logic [IW-1:0]       lv_r   [NLEV+1];
    logic [IW-1:0]       lv_idx [NLEV+1];
    logic [DATA_W-1:0]   lv_dl  [NLEV+1];
    logic [DATA_W-1:0]   lv_acc [NLEV+1];

    logic in_valid_reg, in_query_reg, in_skip_reg;
    logic [IW-1:0] in_l_reg, in_r_reg, in_idx_reg;
    logic [DATA_W-1:0] in_dl_reg;

    logic pend_reg;
    logic [DATA_W-1:0] pend_data_reg;
    logic m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;

    logic accept, out_free, done, pend_move;
    logic [FIELD_W-1:0] f_idx, f_first, f_last;
    logic [DELTA_W-1:0] f_delta;
    logic [31:0] last_c;
    logic empty;

    assign f_idx   = s_tdata[9:0];
    assign f_delta = s_tdata[41:10];
    assign f_first = s_tdata[51:42];
    assign f_last  = s_tdata[61:52];
    assign last_c  = (32'(f_last) >= LEAVES) ? 32'(LEAVES - 1) : 32'(f_last);
    assign empty   = 32'(f_first) > last_c;

    assign clr_done  = 32'(clr_cnt_reg) == PADDED - 1;
    assign s_tready  = (state_reg == TS_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign done      = tok[NLEV].valid;
    assign out_free  = !m_valid_reg || m_tready;
    assign pend_move = pend_reg && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            TS_CLEAR: if (clr_done) state_next = TS_IDLE;
            TS_IDLE:  if (accept) state_next = TS_BUSY;
            TS_BUSY: begin
                if ((done && !tok[NLEV].query) || pend_move) begin
                    state_next = TS_IDLE;
                end
            end
            default:  state_next = TS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= TS_CLEAR;
            clr_cnt_reg  <= '0;
            in_valid_reg <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_reg + IW'(state_reg == TS_CLEAR);
            in_valid_reg <= accept;
            if (done && tok[NLEV].query) begin
                pend_reg <= 1'b1;
            end else if (pend_move) begin
                pend_reg <= 1'b0;
            end
            if (pend_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_query_reg <= (s_tuser == REQ_QUERY);
            in_skip_reg  <= 32'(f_idx) >= LEAVES;
            in_idx_reg   <= IW'(f_idx);
            in_dl_reg    <= DATA_W'(signed'(f_delta));
            in_l_reg     <= IW'(f_first);
            in_r_reg     <= empty ? IW'(f_first) : IW'(last_c + 32'd1);
        end
        if (done && tok[NLEV].query) begin
            pend_data_reg <= lv_acc[NLEV];
        end
        if (pend_move) begin
            m_data_reg <= pend_data_reg;
        end
    end

    assign tok[0]    = '{valid: in_valid_reg, query: in_query_reg, skip: in_skip_reg};
    assign lv_l[0]   = in_l_reg;
    assign lv_r[0]   = in_r_reg;
    assign lv_idx[0] = in_idx_reg;
    assign lv_dl[0]  = in_dl_reg;
    assign lv_acc[0] = '0;

    for (genvar k = 0; k < NLEV; k++) begin : g_lev
        strs_cell #(.DEPTH(PADDED >> k), .IW(IW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clr_en    (state_reg == TS_CLEAR),
            .clr_addr  (clr_cnt_reg),
            .in_tok    (tok[k]),
            .in_l      (lv_l[k]),
            .in_r      (lv_r[k]),
            .in_idx    (lv_idx[k]),
            .in_delta  (lv_dl[k]),
            .in_acc    (lv_acc[k]),
            .out_tok   (tok[k+1]),
            .out_l     (lv_l[k+1]),
            .out_r     (lv_r[k+1]),
            .out_idx   (lv_idx[k+1]),
            .out_delta (lv_dl[k+1]),
            .out_acc   (lv_acc[k+1])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == TS_CLEAR) |-> !s_tready)
        else $error("request accepted during clearing pass");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == TS_BUSY))
        else $error("accepted request did not start");
    a_done_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (state_reg == TS_BUSY))
        else $error("result left the chain while idle");
    a_pend_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && out_free) |=> m_tvalid)
        else $error("pending result was not moved to the output");
endmodule
